// ----- src/lbfbp_pkg.sv -----
package lbfbp_pkg;

	localparam int SIZE_W  = 16;
	localparam int STEP_W  = 16;
	localparam int BIDX_W  = 4;
	localparam int TOTAL_W = 20;
	localparam int SUM_W   = 21;

	localparam logic [SUM_W-1:0]   SUM_MAX = {SUM_W{1'b1}};
	localparam logic [TOTAL_W-1:0] OUT_MAX = {TOTAL_W{1'b1}};

	typedef struct packed {
		logic [SIZE_W-1:0] tensor_size;
		logic [STEP_W-1:0] first_step;
		logic [STEP_W-1:0] last_step;
	} in_t;

	typedef struct packed {
		logic [BIDX_W-1:0]  buffer_index;
		logic               opened_new;
		logic               overflow;
		logic [TOTAL_W-1:0] total_capacity;
	} out_t;

	typedef struct packed {
		logic [SIZE_W-1:0] capacity;
		logic [STEP_W-1:0] release_step;
	} slot_t;

endpackage

// ----- src/lbfbp_slot_mem.sv -----
module lbfbp_slot_mem #(
	parameter int NUM_SLOTS = 16
) (
	input  logic                                               clk,
	input  logic                                               wr_en,
	input  logic [((NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1)-1:0] wr_addr,
	input  lbfbp_pkg::slot_t                                   wr_data,
	input  logic                                               rd_en,
	input  logic [((NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1)-1:0] rd_addr,
	output lbfbp_pkg::slot_t                                   rd_data
);

	lbfbp_pkg::slot_t mem_q [NUM_SLOTS];
	lbfbp_pkg::slot_t rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// ----- src/lbfbp_ctrl.sv -----
module lbfbp_ctrl #(
	parameter int NUM_SLOTS = 16
) (
	input  logic                                               clk,
	input  logic                                               arst_n,
	input  logic                                               in_valid,
	output logic                                               in_ready,
	input  lbfbp_pkg::in_t                                     in_data,
	output logic                                               res_valid,
	input  logic                                               res_ready,
	output lbfbp_pkg::out_t                                    res_data,
	output logic                                               mem_wr_en,
	output logic [((NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1)-1:0] mem_wr_addr,
	output lbfbp_pkg::slot_t                                   mem_wr_data,
	output logic                                               mem_rd_en,
	output logic [((NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1)-1:0] mem_rd_addr,
	input  lbfbp_pkg::slot_t                                   mem_rd_data
);

	localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
	localparam int CNT_W = $clog2(NUM_SLOTS + 1);

	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_SCAN   = 2'd1;
	localparam logic [1:0] ST_DRAIN  = 2'd2;
	localparam logic [1:0] ST_DECIDE = 2'd3;

	logic [1:0]                      state_q;
	lbfbp_pkg::in_t                  item_q;
	logic [IDX_W-1:0]                addr_q;
	logic [CNT_W-1:0]                used_q;
	logic [lbfbp_pkg::SUM_W-1:0]     sum_q;
	logic                            valid_s1;
	logic [IDX_W-1:0]                idx_s1;
	logic                            found_q;
	logic [IDX_W-1:0]                best_idx_q;
	logic [lbfbp_pkg::SIZE_W-1:0]    best_cap_q;

	logic                            accept;
	logic                            last_addr;
	logic                            cand_ok;
	logic                            full;
	logic                            opening;
	logic                            commit;
	logic [lbfbp_pkg::SUM_W:0]       sum_add;
	logic [lbfbp_pkg::SUM_W-1:0]     sum_new;
	logic [lbfbp_pkg::SUM_W-1:0]     sum_out;
	logic [IDX_W+lbfbp_pkg::BIDX_W-1:0] idx_wide;
	logic [IDX_W-1:0]                res_idx;

	assign in_ready  = (state_q == ST_IDLE);
	assign accept    = in_valid && in_ready;
	assign last_addr = (CNT_W'(addr_q) + CNT_W'(1)) == used_q;

	assign cand_ok = valid_s1
		&& (mem_rd_data.release_step < item_q.first_step)
		&& (mem_rd_data.capacity >= item_q.tensor_size)
		&& (!found_q || (mem_rd_data.capacity < best_cap_q));

	assign full    = (used_q == CNT_W'(NUM_SLOTS));
	assign opening = !found_q && !full;
	assign res_valid = (state_q == ST_DECIDE);
	assign commit  = res_valid && res_ready;

	assign sum_add = {1'b0, sum_q} + (lbfbp_pkg::SUM_W + 1)'(item_q.tensor_size);
	assign sum_new = (sum_add > (lbfbp_pkg::SUM_W + 1)'(lbfbp_pkg::SUM_MAX))
		? lbfbp_pkg::SUM_MAX : sum_add[lbfbp_pkg::SUM_W-1:0];
	assign sum_out = opening ? sum_new : sum_q;

	assign res_idx  = found_q ? best_idx_q : (full ? '0 : used_q[IDX_W-1:0]);
	assign idx_wide = (IDX_W + lbfbp_pkg::BIDX_W)'(res_idx);

	always_comb begin
		res_data.buffer_index   = idx_wide[lbfbp_pkg::BIDX_W-1:0];
		res_data.opened_new     = opening;
		res_data.overflow       = !found_q && full;
		res_data.total_capacity =
			(sum_out > lbfbp_pkg::SUM_W'(lbfbp_pkg::OUT_MAX))
			? lbfbp_pkg::OUT_MAX : sum_out[lbfbp_pkg::TOTAL_W-1:0];
	end

	assign mem_rd_en   = (state_q == ST_SCAN);
	assign mem_rd_addr = addr_q;
	assign mem_wr_en   = commit && (found_q || !full);
	assign mem_wr_addr = found_q ? best_idx_q : used_q[IDX_W-1:0];

	always_comb begin
		mem_wr_data.capacity     = found_q ? best_cap_q : item_q.tensor_size;
		mem_wr_data.release_step = item_q.last_step;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			addr_q   <= '0;
			used_q   <= '0;
			sum_q    <= '0;
			valid_s1 <= 1'b0;
			found_q  <= 1'b0;
		end else begin
			valid_s1 <= (state_q == ST_SCAN);
			if (cand_ok) begin
				found_q <= 1'b1;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						found_q <= 1'b0;
						addr_q  <= '0;
						state_q <= (used_q == '0) ? ST_DECIDE : ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (last_addr) begin
						state_q <= ST_DRAIN;
					end else begin
						addr_q <= addr_q + IDX_W'(1);
					end
				end
				ST_DRAIN: begin
					state_q <= ST_DECIDE;
				end
				ST_DECIDE: begin
					if (commit) begin
						if (opening) begin
							used_q <= used_q + CNT_W'(1);
							sum_q  <= sum_new;
						end
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_q <= in_data;
		end
		idx_s1 <= addr_q;
		if (cand_ok) begin
			best_idx_q <= idx_s1;
			best_cap_q <= mem_rd_data.capacity;
		end
	end

endmodule

// ----- src/lifetime_best_fit_buffer_planner_top.sv -----
// Best-fit buffer planner. Each tensor beat (size, first step, last step) is
// matched against the open buffers held in a slot memory: a buffer is free
// when its occupant's last step is below the new first step, and the smallest
// free buffer that fits wins, lowest index on ties; otherwise a new buffer of
// exactly the tensor size opens, or overflow is flagged when all NUM_SLOTS
// slots are open. One result beat per input beat, carrying the buffer index,
// the new-buffer flag, the overflow flag and the saturated running capacity.
// Per item, the single read port of the slot memory visits one open buffer
// per cycle in the scan state (skipped while none is open); a drain state then
// lets the last read return, and the decide state writes back once the result
// is taken. A registered output stage lets the next beat be accepted while a
// result waits. No clearing pass after reset.
module lifetime_best_fit_buffer_planner_top #(
	parameter int NUM_SLOTS = 16
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  lbfbp_pkg::in_t  in_data,
	output logic            out_valid,
	input  logic            out_ready,
	output lbfbp_pkg::out_t out_data
);

	localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

	logic             res_valid;
	logic             res_ready;
	lbfbp_pkg::out_t  res_data;
	logic             mem_wr_en;
	logic [IDX_W-1:0] mem_wr_addr;
	lbfbp_pkg::slot_t mem_wr_data;
	logic             mem_rd_en;
	logic [IDX_W-1:0] mem_rd_addr;
	lbfbp_pkg::slot_t mem_rd_data;
	logic             out_valid_q;
	lbfbp_pkg::out_t  out_data_q;

	lbfbp_ctrl #(
		.NUM_SLOTS(NUM_SLOTS)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_data    (in_data),
		.res_valid  (res_valid),
		.res_ready  (res_ready),
		.res_data   (res_data),
		.mem_wr_en  (mem_wr_en),
		.mem_wr_addr(mem_wr_addr),
		.mem_wr_data(mem_wr_data),
		.mem_rd_en  (mem_rd_en),
		.mem_rd_addr(mem_rd_addr),
		.mem_rd_data(mem_rd_data)
	);

	lbfbp_slot_mem #(
		.NUM_SLOTS(NUM_SLOTS)
	) u_slot_mem (
		.clk    (clk),
		.wr_en  (mem_wr_en),
		.wr_addr(mem_wr_addr),
		.wr_data(mem_wr_data),
		.rd_en  (mem_rd_en),
		.rd_addr(mem_rd_addr),
		.rd_data(mem_rd_data)
	);

	assign res_ready = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ready) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			out_data_q <= res_data;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

`ifndef SYNTH
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken while an item is in progress");

	a_overflow_excl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.overflow |-> !out_data.opened_new
			&& (out_data.buffer_index == '0))
		else $error("overflow beat carries a buffer assignment");

	a_write_on_commit: assert property (@(posedge clk) disable iff (!arst_n)
		mem_wr_en |-> res_valid && res_ready && !mem_rd_en)
		else $error("slot write outside result commit");
`endif

endmodule

// ----- tb/tb_lifetime_best_fit_buffer_planner_top.sv -----
class plan_scoreboard;
	localparam int SLOTS = 16;

	bit [15:0]            buf_capacity[SLOTS];
	bit [15:0]            buf_release[SLOTS];
	int unsigned          open_count;
	int unsigned          capacity_total;
	lbfbp_pkg::out_t      expected_plans[$];
	int unsigned          tensors_seen;
	int unsigned          errors;

	function new();
		open_count = 0;
		capacity_total = 0;
		tensors_seen = 0;
		errors = 0;
	endfunction

	function void note_tensor(lbfbp_pkg::in_t t);
		lbfbp_pkg::out_t plan;
		int  pick;
		bit  found;
		pick = 0;
		found = 0;
		plan = '0;
		for (int i = 0; i < open_count; i++) begin
			if (buf_release[i] < t.first_step && buf_capacity[i] >= t.tensor_size) begin
				if (!found || buf_capacity[i] < buf_capacity[pick]) begin
					pick = i;
					found = 1;
				end
			end
		end
		if (found) begin
			buf_release[pick] = t.last_step;
			plan.buffer_index = pick[3:0];
		end else if (open_count < SLOTS) begin
			buf_capacity[open_count] = t.tensor_size;
			buf_release[open_count] = t.last_step;
			plan.buffer_index = open_count[3:0];
			plan.opened_new = 1'b1;
			open_count++;
			capacity_total = capacity_total + t.tensor_size;
			if (capacity_total > lbfbp_pkg::SUM_MAX)
				capacity_total = lbfbp_pkg::SUM_MAX;
		end else begin
			plan.overflow = 1'b1;
		end
		plan.total_capacity = (capacity_total > lbfbp_pkg::OUT_MAX) ?
			lbfbp_pkg::OUT_MAX : capacity_total[19:0];
		expected_plans.insert(expected_plans.size(), plan);
	endfunction

	function void check_result(lbfbp_pkg::out_t got);
		lbfbp_pkg::out_t want;
		if (expected_plans.size() == 0) begin
			errors++;
			if (errors <= 10)
				$display("unexpected result beat: idx=%0d new=%0b ovf=%0b total=%0d",
					got.buffer_index, got.opened_new, got.overflow,
					got.total_capacity);
			return;
		end
		want = expected_plans.pop_front();
		if (got.buffer_index !== want.buffer_index || got.opened_new !== want.opened_new ||
			got.overflow !== want.overflow || got.total_capacity !== want.total_capacity) begin
			errors++;
			if (errors <= 10)
				$display({"tensor %0d: expected idx=%0d new=%0b ovf=%0b total=%0d,",
					" got idx=%0d new=%0b ovf=%0b total=%0d"},
					tensors_seen, want.buffer_index, want.opened_new, want.overflow,
					want.total_capacity, got.buffer_index, got.opened_new, got.overflow,
					got.total_capacity);
		end
		tensors_seen++;
	endfunction

	function int pending();
		return expected_plans.size();
	endfunction
endclass

module tb_lifetime_best_fit_buffer_planner_top;
	localparam int RANDOM_TENSORS = 1380;
	localparam int QUIET_TAIL     = 200;
	localparam int CYCLE_LIMIT    = 400000;

	logic            clk = 1'b0;
	logic            arst_n = 1'b0;
	logic            in_valid = 1'b0;
	logic            in_ready;
	lbfbp_pkg::in_t  in_data = '0;
	logic            out_valid;
	logic            out_ready = 1'b0;
	lbfbp_pkg::out_t out_data;

	plan_scoreboard sb;
	bit             quiet = 1'b0;
	int             tensors_accepted = 0;
	int             hold_left = 0;
	bit             long_hold_done = 1'b0;
	int             cycles = 0;
	int unsigned    step_now;

	lifetime_best_fit_buffer_planner_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data)
	);

	always #4 clk = ~clk;

	always @(posedge clk) begin
		cycles++;
		if (cycles == CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready)
				sb.check_result(out_data);
			if (hold_left != 0) begin
				out_ready <= 1'b0;
				hold_left <= hold_left - 1;
			end else if (!long_hold_done && tensors_accepted >= 300) begin
				out_ready <= 1'b0;
				hold_left <= 400;
				long_hold_done <= 1'b1;
			end else if (!quiet && $urandom_range(0, 5) == 0) begin
				out_ready <= 1'b0;
				hold_left <= $urandom_range(0, 15);
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	task automatic send_tensor(input int unsigned size, input int unsigned first,
		input int unsigned last);
		lbfbp_pkg::in_t t;
		t.tensor_size = size[15:0];
		t.first_step = first[15:0];
		t.last_step = last[15:0];
		in_valid <= 1'b1;
		in_data <= t;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		sb.note_tensor(t);
		tensors_accepted++;
		if (!quiet && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 16)) @(posedge clk);
		end
	endtask

	task automatic send_random_tensor();
		int unsigned size;
		int unsigned first;
		int unsigned last;
		int unsigned pick;
		pick = $urandom_range(0, 99);
		if (pick < 30)
			size = $urandom_range(0, 120);
		else if (pick < 80)
			size = $urandom_range(0, 50000);
		else
			size = $urandom & 16'hFFFF;
		step_now = (step_now + $urandom_range(0, 80)) & 16'hFFFF;
		first = step_now;
		if ($urandom_range(0, 99) < 3)
			first = (step_now - $urandom_range(1, 60)) & 16'hFFFF;
		pick = $urandom_range(0, 99);
		if (pick < 5)
			last = (first - $urandom_range(1, 200)) & 16'hFFFF;
		else if (pick < 10)
			last = $urandom & 16'hFFFF;
		else
			last = (first + $urandom_range(0, 150)) & 16'hFFFF;
		send_tensor(size, first, last);
	endtask

	initial begin
		int unsigned big_sizes[12];
		sb = new();
		big_sizes = '{40000, 40000, 41000, 45000, 50000, 52000,
			55000, 60000, 61000, 63000, 64000, 65000};
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_tensor(0, 0, 0);
		send_tensor(0, 1, 5);
		send_tensor(65535, 2, 3);
		send_tensor(100, 4, 1000);
		send_tensor(100, 4, 2);
		send_tensor(50, 5, 9);
		send_tensor(3, 3, 8);
		foreach (big_sizes[i])
			send_tensor(big_sizes[i], 20, 40);
		send_tensor(40000, 20, 65535);
		send_tensor(65535, 21, 65535);
		send_tensor(40000, 50, 60);
		send_tensor(0, 50, 55);

		step_now = 60;
		for (int n = 0; n < RANDOM_TENSORS; n++) begin
			if (n == RANDOM_TENSORS - QUIET_TAIL)
				quiet = 1'b1;
			send_random_tensor();
		end
		in_valid <= 1'b0;

		while (sb.pending() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
		if (sb.errors == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end
endmodule

// ----- lifetime_best_fit_buffer_planner_top.f -----
src/lbfbp_pkg.sv
src/lbfbp_slot_mem.sv
src/lbfbp_ctrl.sv
src/lifetime_best_fit_buffer_planner_top.sv
tb/tb_lifetime_best_fit_buffer_planner_top.sv
